// ----- hw/rtl/m3i_pkg.sv -----
package m3i_pkg;

   localparam int NUM_ELEM = 9;
   localparam int DET_TERMS = 3;
   localparam int FRONT_STAGES = 6;

   typedef logic [3:0] elem_idx_type;

   // element index is column * 3 + row; cofactor k = m[a] * m[b] - m[c] * m[d]
   localparam elem_idx_type COF_IDX [NUM_ELEM][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd6, 4'd1, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
   };

   // first-row expansion: m[0] * cof[0] + m[3] * cof[1] + m[6] * cof[2]
   localparam elem_idx_type DET_IDX [DET_TERMS] = '{4'd0, 4'd3, 4'd6};

endpackage

// ----- hw/rtl/m3i_front.sv -----
module m3i_front import m3i_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS = 16,
   localparam int COF_W = 2 * DATA_WIDTH + 1,
   localparam int NUM_W = COF_W + 2 * FRAC_BITS,
   localparam int DET_W = 3 * DATA_WIDTH + 3
) (
   input  logic                         clock,
   input  logic [FRONT_STAGES-1:0]      stage_en,
   input  logic signed [DATA_WIDTH-1:0] mat_in [NUM_ELEM],
   output logic [NUM_W-1:0]             num_out [NUM_ELEM],
   output logic [NUM_ELEM-1:0]          neg_out,
   output logic [DET_W-1:0]             dmag_out,
   output logic                         singular_out
);

   typedef logic signed [DATA_WIDTH-1:0]   elem_type;
   typedef logic signed [2*DATA_WIDTH-1:0] prod_type;
   typedef logic signed [COF_W-1:0]        cof_type;
   typedef logic signed [2*DATA_WIDTH:0]   part_type;
   typedef logic signed [DET_W-1:0]        det_type;

   elem_type mat_ff [NUM_ELEM];
   prod_type pa_ff [NUM_ELEM];
   prod_type pb_ff [NUM_ELEM];
   elem_type mat1_ff [DET_TERMS];
   elem_type mat2_ff [DET_TERMS];
   cof_type  cof2_ff [NUM_ELEM];
   cof_type  cof3_ff [NUM_ELEM];
   cof_type  cof4_ff [NUM_ELEM];
   part_type plo_ff [DET_TERMS];
   part_type phi_ff [DET_TERMS];
   det_type  det_ff;
   det_type  det_in;
   logic [COF_W-1:0] cof_mag [NUM_ELEM];
   logic [NUM_W-1:0] num_ff [NUM_ELEM];
   logic [NUM_ELEM-1:0] neg_ff;
   logic [DET_W-1:0] dmag_ff;
   logic [DET_W-1:0] dmag_in;
   logic singular_ff;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         mat_ff <= mat_in;
      end
      if (stage_en[1]) begin
         for (int k = 0; k < NUM_ELEM; k++) begin
            pa_ff[k] <= prod_type'(mat_ff[COF_IDX[k][0]]) * prod_type'(mat_ff[COF_IDX[k][1]]);
            pb_ff[k] <= prod_type'(mat_ff[COF_IDX[k][2]]) * prod_type'(mat_ff[COF_IDX[k][3]]);
         end
         for (int j = 0; j < DET_TERMS; j++) begin
            mat1_ff[j] <= mat_ff[DET_IDX[j]];
         end
      end
      if (stage_en[2]) begin
         for (int k = 0; k < NUM_ELEM; k++) begin
            cof2_ff[k] <= cof_type'(pa_ff[k]) - cof_type'(pb_ff[k]);
         end
         mat2_ff <= mat1_ff;
      end
      // cofactor split in a low unsigned and a high signed half
      if (stage_en[3]) begin
         for (int j = 0; j < DET_TERMS; j++) begin
            plo_ff[j] <= part_type'(mat2_ff[j])
                         * part_type'($signed({1'b0, cof2_ff[j][DATA_WIDTH-1:0]}));
            phi_ff[j] <= part_type'(mat2_ff[j])
                         * part_type'($signed(cof2_ff[j][2*DATA_WIDTH:DATA_WIDTH]));
         end
         cof3_ff <= cof2_ff;
      end
      if (stage_en[4]) begin
         det_ff  <= det_in;
         cof4_ff <= cof3_ff;
      end
      if (stage_en[5]) begin
         for (int k = 0; k < NUM_ELEM; k++) begin
            num_ff[k] <= {cof_mag[k], {(2 * FRAC_BITS){1'b0}}};
            neg_ff[k] <= cof4_ff[k][COF_W-1] ^ det_ff[DET_W-1];
         end
         dmag_ff     <= dmag_in;
         singular_ff <= (det_ff == '0);
      end
   end

   always_comb begin
      det_in = '0;
      for (int j = 0; j < DET_TERMS; j++) begin
         det_in = det_in + (det_type'(phi_ff[j]) <<< DATA_WIDTH) + det_type'(plo_ff[j]);
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_ELEM; k++) begin
         cof_mag[k] = cof4_ff[k][COF_W-1] ? COF_W'(-cof4_ff[k]) : COF_W'(cof4_ff[k]);
      end
      dmag_in = det_ff[DET_W-1] ? DET_W'(-det_ff) : DET_W'(det_ff);
   end

   assign num_out      = num_ff;
   assign neg_out      = neg_ff;
   assign dmag_out     = dmag_ff;
   assign singular_out = singular_ff;

endmodule

// ----- hw/rtl/m3i_lane.sv -----
module m3i_lane #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS = 16,
   localparam int NUM_W = 2 * DATA_WIDTH + 1 + 2 * FRAC_BITS,
   localparam int DET_W = 3 * DATA_WIDTH + 3,
   localparam int DIV_STAGES = DATA_WIDTH + 2
) (
   input  logic                         clock,
   input  logic [DIV_STAGES:0]          stage_en,
   input  logic [NUM_W-1:0]             num_in,
   input  logic [DET_W-1:0]             dmag_in,
   input  logic                         neg_in,
   output logic signed [DATA_WIDTH-1:0] result_out
);

   localparam int SHIFT_W = DET_W + DATA_WIDTH + 1;
   localparam int CMP_W = (NUM_W > SHIFT_W) ? NUM_W : SHIFT_W;
   localparam int QW = DIV_STAGES;
   localparam logic [QW-1:0] HALF = QW'(1) << (DATA_WIDTH - 1);
   localparam logic [DATA_WIDTH-1:0] POS_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] NEG_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

   logic [CMP_W-1:0] rem_ff [DIV_STAGES];
   logic [QW-1:0]    q_ff [DIV_STAGES];
   logic [DET_W-1:0] dmag_ff [DIV_STAGES];
   logic             neg_ff [DIV_STAGES];
   logic [QW-1:0]    q_fin;
   logic signed [DATA_WIDTH-1:0] result_ff;
   logic signed [DATA_WIDTH-1:0] result_in;

   // restoring division, one quotient bit per stage, the final quotient saturates to the signed range
   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      localparam int SH = DIV_STAGES - 1 - j;
      logic [CMP_W-1:0] rem_prev;
      logic [QW-1:0]    q_prev;
      logic [DET_W-1:0] d_prev;
      logic             n_prev;
      logic [CMP_W:0]   diff;

      if (j == 0) begin : g_first
         assign rem_prev = CMP_W'(num_in);
         assign q_prev   = '0;
         assign d_prev   = dmag_in;
         assign n_prev   = neg_in;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign q_prev   = q_ff[j-1];
         assign d_prev   = dmag_ff[j-1];
         assign n_prev   = neg_ff[j-1];
      end

      assign diff = {1'b0, rem_prev} - {1'b0, (CMP_W'(d_prev) << SH)};

      always_ff @(posedge clock) begin
         if (stage_en[j]) begin
            rem_ff[j]  <= diff[CMP_W] ? rem_prev : diff[CMP_W-1:0];
            q_ff[j]    <= {q_prev[QW-2:0], ~diff[CMP_W]};
            dmag_ff[j] <= d_prev;
            neg_ff[j]  <= n_prev;
         end
      end
   end

   assign q_fin = q_ff[DIV_STAGES-1];

   always_comb begin
      if (neg_ff[DIV_STAGES-1]) begin
         result_in = (q_fin > HALF) ? NEG_MIN : DATA_WIDTH'(QW'(0) - q_fin);
      end else begin
         result_in = (q_fin > (HALF - QW'(1))) ? POS_MAX : DATA_WIDTH'(q_fin);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[DIV_STAGES]) begin
         result_ff <= result_in;
      end
   end

   assign result_out = result_ff;

endmodule

// ----- hw/rtl/matrix3_inverse.sv -----
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | req_tdata: nine elements r0c0 r1c0 r2c0 r0c1 ... r2c2
// rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata: nine inverse elements, rsp_tuser: singular
//
// one matrix per cycle while rsp_tready does not hold the output back
// most of the pipeline depth comes from the restoring divider in each of the nine lanes, one quotient bit a stage
// reset clears only the stage valid bits, the datapath carries no reset
// each stage holds when it is full and the next one is stalled, so bubbles close up
// and items are taken while a result waits on rsp, until the pipeline is full
module matrix3_inverse import m3i_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // in_r0c0, in_r1c0, in_r2c0, in_r0c1, in_r1c1, in_r2c1, in_r0c2, in_r1c2, in_r2c2
   input  logic [((NUM_ELEM * DATA_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_r0c0, out_r1c0, out_r2c0, out_r0c1, out_r1c1, out_r2c1, out_r0c2, out_r1c2, out_r2c2
   output logic [((NUM_ELEM * DATA_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   // singular
   output logic [0:0] rsp_tuser
);

   localparam int TDATA_W = ((NUM_ELEM * DATA_WIDTH + 7) / 8) * 8;
   localparam int PAD_W = TDATA_W - NUM_ELEM * DATA_WIDTH;
   localparam int NUM_W = 2 * DATA_WIDTH + 1 + 2 * FRAC_BITS;
   localparam int DET_W = 3 * DATA_WIDTH + 3;
   localparam int DIV_STAGES = DATA_WIDTH + 2;
   localparam int LANE_BASE = FRONT_STAGES;
   localparam int NS = FRONT_STAGES + DIV_STAGES + 2;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;
   logic [NS-1:0] stage_en;
   logic signed [DATA_WIDTH-1:0] mat [NUM_ELEM];
   logic [NUM_W-1:0] num [NUM_ELEM];
   logic [NUM_ELEM-1:0] neg;
   logic [DET_W-1:0] dmag;
   logic singular;
   logic signed [DATA_WIDTH-1:0] lane_res [NUM_ELEM];
   logic [DIV_STAGES:0] sing_ff;
   logic signed [DATA_WIDTH-1:0] out_ff [NUM_ELEM];
   logic out_sing_ff;

   // a stage may load when it is empty or the stage after it moves on
   always_comb begin
      stage_en[NS-1] = !v_ff[NS-1] || rsp_tready;
      for (int i = NS - 2; i >= 0; i--) begin
         stage_en[i] = !v_ff[i] || stage_en[i+1];
      end
   end

   always_comb begin
      v_in[0] = stage_en[0] ? req_tvalid : v_ff[0];
      for (int i = 1; i < NS; i++) begin
         if (stage_en[i]) begin
            v_in[i] = v_ff[i-1];
         end else begin
            v_in[i] = v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_tready = stage_en[0];

   always_comb begin
      for (int k = 0; k < NUM_ELEM; k++) begin
         mat[k] = req_tdata[k*DATA_WIDTH +: DATA_WIDTH];
      end
   end

   m3i_front #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock        (clock),
      .stage_en     (stage_en[FRONT_STAGES-1:0]),
      .mat_in       (mat),
      .num_out      (num),
      .neg_out      (neg),
      .dmag_out     (dmag),
      .singular_out (singular)
   );

   for (genvar k = 0; k < NUM_ELEM; k++) begin : g_lane
      m3i_lane #(
         .DATA_WIDTH (DATA_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_lane (
         .clock      (clock),
         .stage_en   (stage_en[LANE_BASE +: DIV_STAGES + 1]),
         .num_in     (num[k]),
         .dmag_in    (dmag),
         .neg_in     (neg[k]),
         .result_out (lane_res[k])
      );
   end

   // singular flag rides alongside the lanes
   always_ff @(posedge clock) begin
      if (stage_en[LANE_BASE]) begin
         sing_ff[0] <= singular;
      end
      for (int t = 1; t <= DIV_STAGES; t++) begin
         if (stage_en[LANE_BASE + t]) begin
            sing_ff[t] <= sing_ff[t-1];
         end
      end
   end

   // merge: gather the nine lanes, zero everything for a singular matrix
   always_ff @(posedge clock) begin
      if (stage_en[NS-1]) begin
         for (int k = 0; k < NUM_ELEM; k++) begin
            out_ff[k] <= sing_ff[DIV_STAGES] ? '0 : lane_res[k];
         end
         out_sing_ff <= sing_ff[DIV_STAGES];
      end
   end

   always_comb begin
      rsp_tdata = '0;
      for (int k = 0; k < NUM_ELEM; k++) begin
         rsp_tdata[k*DATA_WIDTH +: DATA_WIDTH] = out_ff[k];
      end
      if (PAD_W > 0) begin
         rsp_tdata[TDATA_W-1 -: ((PAD_W > 0) ? PAD_W : 1)] = '0;
      end
   end

   assign rsp_tvalid   = v_ff[NS-1];
   assign rsp_tuser[0] = out_sing_ff;

`ifndef NO_ASSERTIONS
   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("singular item with nonzero elements");

   a_ready_when_drained : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("input stalled although the output moves");

   a_occupancy : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !(rsp_tvalid && rsp_tready)
      |=> $countones(v_ff) == $past($countones(v_ff)) + 1)
      else $error("pipeline lost or duplicated an item");
`endif

endmodule
